[rtl/assert_macros.svh]
// Assertion macros for the checker file of this block.
// Depends on nothing; each user supplies clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define VLAB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vlab assertion failed");

// Checked on every rising edge, reset included.
`define VLAB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("vlab assertion failed");

`endif

[rtl/vlab_pkg.sv]
`timescale 1ns / 1ps
// Package for the vector lerp and additive blend block: opcode codes,
// float constants, pipeline latency and a leading-zero counter.
package vlab_pkg;

  typedef enum logic {
    OP_LERP     = 1'b0,
    OP_ADDITIVE = 1'b1
  } opcode_e;

  typedef logic [31:0] fp32_t;

  localparam fp32_t CANON_NAN = 32'h7FC0_0000;
  localparam logic [7:0] EXP_MAX = 8'hFF;

  // Cycles from item entry to the registered lane result.
  localparam int LANE_LAT = 7;

  localparam int unsigned CNT_W = 3;

  function automatic logic [5:0] clz48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        n = 6'(47 - i);
      end
    end
    return n;
  endfunction

endpackage

[rtl/vlab_fp_add.sv]
`timescale 1ns / 1ps
// Two-stage fp32 adder, round to nearest even, subnormals kept.
// Depends on vlab_pkg.
module vlab_fp_add (
  input  logic                clk_i,
  input  logic                en_i,
  input  vlab_pkg::fp32_t     a_i,
  input  vlab_pkg::fp32_t     b_i,
  output vlab_pkg::fp32_t     sum_o
);

  logic        a_nan, b_nan, a_inf, b_inf, swap, sub;
  vlab_pkg::fp32_t x, y;
  logic [7:0]  ex, ey, d;
  logic [26:0] mx3, my3, ys;
  logic [27:0] sum_d;

  logic [27:0] sum_q;
  logic [7:0]  exp_q;
  logic        sign_q, sub_q, nan_q, inf_q;
  vlab_pkg::fp32_t res_q, res_d;

  always_comb begin
    a_nan = (a_i[30:23] == vlab_pkg::EXP_MAX) && (a_i[22:0] != '0);
    b_nan = (b_i[30:23] == vlab_pkg::EXP_MAX) && (b_i[22:0] != '0);
    a_inf = (a_i[30:23] == vlab_pkg::EXP_MAX) && (a_i[22:0] == '0);
    b_inf = (b_i[30:23] == vlab_pkg::EXP_MAX) && (b_i[22:0] == '0);
    swap  = a_i[30:0] < b_i[30:0];
    x     = swap ? b_i : a_i;
    y     = swap ? a_i : b_i;
    sub   = x[31] ^ y[31];
    ex    = (x[30:23] == '0) ? 8'd1 : x[30:23];
    ey    = (y[30:23] == '0) ? 8'd1 : y[30:23];
    d     = ex - ey;
    mx3   = {(x[30:23] != '0), x[22:0], 3'b000};
    my3   = {(y[30:23] != '0), y[22:0], 3'b000};
    if (d >= 8'd27) begin
      ys = {26'd0, (my3 != '0)};
    end else begin
      ys = (my3 >> d) | {26'd0, ((my3 & ((27'd1 << d) - 27'd1)) != '0)};
    end
    sum_d = sub ? ({1'b0, mx3} - {1'b0, ys}) : ({1'b0, mx3} + {1'b0, ys});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q  <= sum_d;
      exp_q  <= ex;
      sign_q <= x[31];
      sub_q  <= sub;
      nan_q  <= a_nan | b_nan | (a_inf & b_inf & sub);
      inf_q  <= a_inf | b_inf;
    end
  end

  logic [5:0]  lz28, lz27;
  logic [7:0]  lim;
  logic [4:0]  sh;
  logic [26:0] m;
  logic [8:0]  e;
  logic        up, sgn;
  logic [24:0] mr;
  logic [23:0] mant;

  always_comb begin
    lz28 = vlab_pkg::clz48({sum_q, 20'hFFFFF});
    lz27 = lz28 - 6'd1;
    lim  = exp_q - 8'd1;
    m    = '0;
    sh   = '0;
    e    = '0;
    if (sum_q[27]) begin
      m = {sum_q[27:2], sum_q[1] | sum_q[0]};
      e = {1'b0, exp_q} + 9'd1;
    end else begin
      sh = ({2'b00, lz27} < lim) ? lz27[4:0] : lim[4:0];
      m  = sum_q[26:0] << sh;
      e  = {1'b0, exp_q} - {4'd0, sh};
    end
    up = m[2] & (m[1] | m[0] | m[3]);
    mr = {1'b0, m[26:3]} + {24'd0, up};
    if (mr[24]) begin
      mant = mr[24:1];
      e    = e + 9'd1;
    end else begin
      mant = mr[23:0];
    end
    sgn = (sum_q == '0) ? (sub_q ? 1'b0 : sign_q) : sign_q;
    if (nan_q) begin
      res_d = vlab_pkg::CANON_NAN;
    end else if (inf_q || (mant[23] && (e >= 9'd255))) begin
      res_d = {sgn, vlab_pkg::EXP_MAX, 23'd0};
    end else begin
      res_d = {sgn, (mant[23] ? e[7:0] : 8'd0), mant[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign sum_o = res_q;

endmodule

[rtl/vlab_fp_mul.sv]
`timescale 1ns / 1ps
// Three-stage fp32 multiplier, round to nearest even, subnormals kept.
// Depends on vlab_pkg.
module vlab_fp_mul (
  input  logic            clk_i,
  input  logic            en_i,
  input  vlab_pkg::fp32_t a_i,
  input  vlab_pkg::fp32_t b_i,
  output vlab_pkg::fp32_t prod_o
);

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;

  logic [47:0] p_q;
  logic signed [10:0] es_q;
  logic sign1_q, nan1_q, inf1_q, zero1_q;

  always_comb begin
    a_nan  = (a_i[30:23] == vlab_pkg::EXP_MAX) && (a_i[22:0] != '0);
    b_nan  = (b_i[30:23] == vlab_pkg::EXP_MAX) && (b_i[22:0] != '0);
    a_inf  = (a_i[30:23] == vlab_pkg::EXP_MAX) && (a_i[22:0] == '0);
    b_inf  = (b_i[30:23] == vlab_pkg::EXP_MAX) && (b_i[22:0] == '0);
    a_zero = (a_i[30:0] == '0);
    b_zero = (b_i[30:0] == '0);
    ma     = {(a_i[30:23] != '0), a_i[22:0]};
    mb     = {(b_i[30:23] != '0), b_i[22:0]};
    ea     = (a_i[30:23] == '0) ? 8'd1 : a_i[30:23];
    eb     = (b_i[30:23] == '0) ? 8'd1 : b_i[30:23];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= ma * mb;
      es_q    <= $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
      sign1_q <= a_i[31] ^ b_i[31];
      nan1_q  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      inf1_q  <= a_inf | b_inf;
      zero1_q <= a_zero | b_zero;
    end
  end

  logic [5:0]  lz;
  logic [47:0] pn, shr;
  logic signed [10:0] ebig, shs;
  logic [23:0] mant_d;
  logic        g_d, st_d, lost;
  logic [9:0]  e_d;

  always_comb begin
    lz   = vlab_pkg::clz48(p_q);
    pn   = p_q << lz;
    ebig = es_q + 11'sd1 - $signed({5'd0, lz});
    shs  = 11'sd1 - ebig;
    shr  = '0;
    lost = 1'b0;
    if (ebig >= 11'sd1) begin
      shr  = pn;
      e_d  = ebig[9:0];
    end else begin
      e_d = 10'd1;
      if (shs > 11'sd48) begin
        shr  = '0;
        lost = (pn != '0);
      end else begin
        shr  = pn >> shs[5:0];
        lost = ((pn & ((48'd1 << shs[5:0]) - 48'd1)) != '0);
      end
    end
    mant_d = shr[47:24];
    g_d    = shr[23];
    st_d   = (shr[22:0] != '0) | lost;
  end

  logic [23:0] mant_q;
  logic        g_q, st_q, sign2_q, nan2_q, inf2_q, zero2_q;
  logic [9:0]  e_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mant_q  <= mant_d;
      g_q     <= g_d;
      st_q    <= st_d;
      e_q     <= e_d;
      sign2_q <= sign1_q;
      nan2_q  <= nan1_q;
      inf2_q  <= inf1_q;
      zero2_q <= zero1_q;
    end
  end

  logic [24:0] mr;
  logic [23:0] mant;
  logic [9:0]  e;
  vlab_pkg::fp32_t res_d, res_q;

  always_comb begin
    mr = {1'b0, mant_q} + {24'd0, g_q & (st_q | mant_q[0])};
    e  = e_q;
    if (mr[24]) begin
      mant = mr[24:1];
      e    = e_q + 10'd1;
    end else begin
      mant = mr[23:0];
    end
    if (nan2_q) begin
      res_d = vlab_pkg::CANON_NAN;
    end else if (inf2_q || (mant[23] && (e >= 10'd255))) begin
      res_d = {sign2_q, vlab_pkg::EXP_MAX, 23'd0};
    end else if (zero2_q) begin
      res_d = {sign2_q, 31'd0};
    end else begin
      res_d = {sign2_q, (mant[23] ? e[7:0] : 8'd0), mant[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign prod_o = res_q;

endmodule

[rtl/vlab_lane.sv]
`timescale 1ns / 1ps
// One blend lane: difference, scale by weight, add to base, zero if unused.
// Depends on vlab_pkg, vlab_fp_add and vlab_fp_mul.
module vlab_lane (
  input  logic              clk_i,
  input  logic              en_i,
  input  vlab_pkg::opcode_e op_i,
  input  logic              active_i,
  input  vlab_pkg::fp32_t   base_i,
  input  vlab_pkg::fp32_t   target_i,
  input  vlab_pkg::fp32_t   reference_i,
  input  vlab_pkg::fp32_t   weight_i,
  output vlab_pkg::fp32_t   res_o
);

  vlab_pkg::fp32_t other, neg_other, diff, prod, sum;
  vlab_pkg::fp32_t base_q [5];
  vlab_pkg::fp32_t weight_q [2];
  logic [vlab_pkg::LANE_LAT-1:0] active_q;

  assign other     = (op_i == vlab_pkg::OP_ADDITIVE) ? reference_i : base_i;
  assign neg_other = {~other[31], other[30:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q[0]   <= base_i;
      for (int i = 1; i < 5; i++) begin
        base_q[i] <= base_q[i-1];
      end
      weight_q[0] <= weight_i;
      weight_q[1] <= weight_q[0];
      active_q    <= {active_q[vlab_pkg::LANE_LAT-2:0], active_i};
    end
  end

  vlab_fp_add u_sub (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (target_i),
    .b_i   (neg_other),
    .sum_o (diff)
  );

  vlab_fp_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .a_i    (diff),
    .b_i    (weight_q[1]),
    .prod_o (prod)
  );

  vlab_fp_add u_add (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (base_q[4]),
    .b_i   (prod),
    .sum_o (sum)
  );

  assign res_o = active_q[vlab_pkg::LANE_LAT-1] ? sum : '0;

endmodule

[rtl/vector_lerp_additive_blend.sv]
`timescale 1ns / 1ps
// Top level of the fp32 vector lerp and additive blend block.
// Depends on vlab_pkg and vlab_lane.
//
// An item enters on the s_axis channel: base, target and reference vectors
// of up to four fp32 components, one fp32 weight, the opcode on tuser and
// the batch-end mark on tlast. The m_axis channel returns one item per input
// with the blended components and the batch-end mark on tlast.
// Each component has a lane of its own; every lane is a seven-register
// pipeline of subtractor, multiplier and adder. One item is accepted per
// cycle while the receiver does not hold back a waiting result.
// Components at or beyond the count are zero; a count of zero acts as one.
// The component count sits at APB address 0 and resets to four.
// Reset empties the pipeline. When the receiver holds tready low while a
// result waits, the whole pipeline freezes and s_axis_tready drops with it;
// nothing is lost.
module vector_lerp_additive_blend #(
  parameter int MAX_COMPONENTS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // base_xy, base_zw, target_xy, target_zw, reference_xy, reference_zw,
  // blend_weight
  input  logic [415:0] s_axis_tdata,
  // opcode
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_xy, out_zw
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int LAT = vlab_pkg::LANE_LAT;

  logic [vlab_pkg::CNT_W-1:0] count_q, n_eff;
  logic [LAT-1:0] vld_q, last_q;
  logic en;
  vlab_pkg::fp32_t res [4];

  assign pready = 1'b1;
  assign prdata = {29'd0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd4;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      count_q <= pwdata[2:0];
    end
  end

  always_comb begin
    n_eff = count_q;
    if (count_q == '0) begin
      n_eff = 3'd1;
    end else if (count_q > 3'(MAX_COMPONENTS)) begin
      n_eff = 3'(MAX_COMPONENTS);
    end
  end

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= {last_q[LAT-2:0], s_axis_tlast};
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    if (k < MAX_COMPONENTS) begin : g_on
      vlab_lane u_lane (
        .clk_i       (clk_i),
        .en_i        (en),
        .op_i        (vlab_pkg::opcode_e'(s_axis_tuser)),
        .active_i    (3'(k) < n_eff),
        .base_i      (s_axis_tdata[  0 + 32*k +: 32]),
        .target_i    (s_axis_tdata[128 + 32*k +: 32]),
        .reference_i (s_axis_tdata[256 + 32*k +: 32]),
        .weight_i    (s_axis_tdata[384 +: 32]),
        .res_o       (res[k])
      );
    end else begin : g_off
      assign res[k] = '0;
    end
  end

  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tlast  = last_q[LAT-1];
  assign m_axis_tdata  = {res[3], res[2], res[1], res[0]};

endmodule

[rtl/vlab_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for vector_lerp_additive_blend, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module vlab_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [31:0]  prdata,
  input logic         pready
);

  `VLAB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `VLAB_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready)
  `VLAB_ASSERT(a_stall_backpressure, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
  `VLAB_ASSERT(a_scalar_zero_fill, m_axis_tvalid && (prdata[2:0] == 3'd0 || prdata[2:0] == 3'd1) |-> m_axis_tdata[127:32] == 96'd0)
  `VLAB_ASSERT_ALWAYS(a_pready_high, pready)

endmodule

bind vector_lerp_additive_blend vlab_checker u_vlab_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .prdata        (prdata),
  .pready        (pready)
);
